// ===== sv/lphs_pkg.sv =====
// Shared types and constants of the linear probe hash set.
// Request and response word layouts, operation and status codes.
// No dependencies.
package lphs_pkg;

   // fixed field widths of the channels
   localparam int KIND_W   = 2;
   localparam int KEY_W    = 21;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 8;
   localparam int SIZE_W   = 9;
   localparam int CSR_W    = 9;

   // reset value of the initial size register
   localparam logic [CSR_W-1:0] INIT_SIZE_RST = 9'd16;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOOKUP = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_DELETE = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_PRESENT = 2'd1,
      ST_ABSENT  = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef struct packed {
      kind_type         kind;
      logic [KEY_W-1:0] key;
   } req_word_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot_index;
      logic [SIZE_W-1:0] current_size;
   } rsp_word_type;

endpackage

// ===== sv/lphs_mod.sv =====
// Iterative remainder unit: dividend modulo divisor, one quotient bit a cycle.
// Shared by the home slot computations of the hash set core.
// No package dependencies.
module lphs_mod #(
   parameter int KEY_BITS = 21,
   parameter int SIZE_W   = 9
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [KEY_BITS-1:0] dividend,
   input  logic [SIZE_W-1:0]   divisor,
   output logic                done,
   output logic [SIZE_W-1:0]   remainder
);

   localparam int CNT_W = $clog2(KEY_BITS + 1);

   logic [KEY_BITS-1:0] num_ff;
   logic [SIZE_W-1:0]   div_ff;
   logic [SIZE_W-1:0]   rem_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                done_ff;
   logic [SIZE_W-1:0]   trial;
   logic [SIZE_W-1:0]   rem_in;

   // shift in the next dividend bit, subtract the divisor when it fits
   always_comb begin
      trial  = {rem_ff[SIZE_W-2:0], num_ff[KEY_BITS-1]};
      rem_in = (trial >= div_ff) ? trial - div_ff : trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            num_ff <= dividend;
            div_ff <= divisor;
            rem_ff <= '0;
            cnt_ff <= CNT_W'(KEY_BITS);
         end else if (cnt_ff != '0) begin
            rem_ff <= rem_in;
            num_ff <= {num_ff[KEY_BITS-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== sv/linear_probe_hash_set_core.sv =====
// Linear probe hash set core: sequencer, two key banks and valid bits.
// Depends on lphs_pkg (word types, codes) and lphs_mod (remainder unit).
//
//   channel   ports                          direction  handshake
//   request   start, busy, req_word          in         start high and busy low
//   response  rsp_strobe, rsp_word           out        one-cycle strobe, no stall
//   config    csr_wr_en, csr_wr_data         in         write enable, no wait
//
// Clear is handled in the idle state. Other words compute the home slot in the
// remainder unit, then probe slots, each with one key bank read. Delete then walks
// the slots after the hole and computes the home of each one. A resize sweeps the old
// slots, one per cycle while they are empty, and runs one home computation and probe per live key.
// Reset is synchronous; it empties the table and loads a size of 16.
// The response strobe lasts one cycle; the receiver cannot stall it.
module linear_probe_hash_set_core #(
   parameter int MAX_SLOTS = 256,
   parameter int KEY_BITS  = 21
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  lphs_pkg::req_word_type           req_word,
   output logic                             rsp_strobe,
   output lphs_pkg::rsp_word_type           rsp_word,
   input  logic                             csr_wr_en,
   input  logic [lphs_pkg::CSR_W-1:0]       csr_wr_data
);

   localparam int IW = $clog2(MAX_SLOTS);
   localparam int SW = IW + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_HOME, S_HWAIT, S_PRD, S_PCMP, S_DISP,
      S_RS_RD, S_RS_KEY, S_RM_STEP, S_RM_KEY, S_RM_WAIT
   } state_type;

   typedef enum logic [1:0] {P_FOUND, P_EMPTY, P_NONE} probe_type;
   typedef enum logic [1:0] {R_FIRST, R_SECOND, R_REHASH} ret_type;
   typedef enum logic [2:0] {A_RESP, A_RESIZE, A_PLACE, A_REMOVE, A_REHASH} act_type;

   // clamp a configured size into the legal range
   function automatic logic [SW-1:0] clamp_size(input logic [lphs_pkg::CSR_W-1:0] v);
      logic [SW-1:0] r;
      if (v < lphs_pkg::CSR_W'(2)) begin
         r = SW'(2);
      end else if (int'(v) > MAX_SLOTS) begin
         r = SW'(MAX_SLOTS);
      end else begin
         r = SW'(v);
      end
      return r;
   endfunction

   state_type                    state_ff;
   ret_type                      ret_ff;
   probe_type                    pres_ff;
   lphs_pkg::kind_type           kind_ff;
   lphs_pkg::status_type         status_ff;
   logic [KEY_BITS-1:0]          key_ff;
   logic [KEY_BITS-1:0]          probe_key_ff;
   logic [KEY_BITS-1:0]          jkey_ff;
   logic [lphs_pkg::CSR_W-1:0]   init_ff;
   logic [SW-1:0]                size_ff;
   logic [SW-1:0]                occ_ff;
   logic [SW-1:0]                old_size_ff;
   logic [SW-1:0]                i_ff;
   logic [SW-1:0]                pcnt_ff;
   logic [SW-1:0]                n_ff;
   logic [IW-1:0]                idx_ff;
   logic [IW-1:0]                pidx_ff;
   logic [IW-1:0]                hole_ff;
   logic [IW-1:0]                j_ff;
   logic [IW-1:0]                slot_ff;
   logic                         bank_ff;
   logic                         rsp_strobe_ff;
   logic [1:0][MAX_SLOTS-1:0]    valid_ff;

   logic [KEY_BITS-1:0] keys0 [MAX_SLOTS];
   logic [KEY_BITS-1:0] keys1 [MAX_SLOTS];
   logic [KEY_BITS-1:0] rd0_ff;
   logic [KEY_BITS-1:0] rd1_ff;

   logic [MAX_SLOTS-1:0] valid_live;
   logic [MAX_SLOTS-1:0] valid_old;
   logic [KEY_BITS-1:0]  rd_live;
   logic [KEY_BITS-1:0]  rd_old;
   logic [31:0]          key_wide;
   logic [KEY_BITS-1:0]  key_in;
   logic [SW-1:0]        idx_sum;
   logic [IW-1:0]        idx_nx;
   logic [SW-1:0]        j_sum;
   logic [IW-1:0]        jn;
   logic [IW-1:0]        raddr;
   logic                 mem_we;
   logic [IW-1:0]        waddr;
   logic [KEY_BITS-1:0]  wdata;
   logic                 mod_start;
   logic [KEY_BITS-1:0]  mod_a;
   logic                 mod_done;
   logic [SW-1:0]        mod_rem;
   logic [IW-1:0]        k_home;
   logic                 stays;
   logic [SW:0]          size_dbl;
   logic                 grow_over;
   logic                 is_full;
   logic                 shrink_due;
   logic                 found;
   logic                 place_ok;
   act_type              act;
   lphs_pkg::status_type a_status;
   logic [IW-1:0]        a_slot;
   logic [SW-1:0]        a_size;
   logic [31:0]          slot_wide;
   logic [31:0]          size_wide;

   // pick live and old bank views
   always_comb begin
      valid_live = valid_ff[bank_ff];
      valid_old  = valid_ff[~bank_ff];
      rd_live    = bank_ff ? rd1_ff : rd0_ff;
      rd_old     = bank_ff ? rd0_ff : rd1_ff;
      key_wide   = 32'(req_word.key);
      key_in     = key_wide[KEY_BITS-1:0];
   end

   // advance probe and shift pointers with wraparound
   always_comb begin
      idx_sum = SW'(idx_ff) + SW'(1);
      idx_nx  = (idx_sum == size_ff) ? '0 : idx_sum[IW-1:0];
      j_sum   = SW'(j_ff) + SW'(1);
      jn      = (j_sum == size_ff) ? '0 : j_sum[IW-1:0];
   end

   // backward shift test: does the entry at j stay between hole and j
   always_comb begin
      k_home = mod_rem[IW-1:0];
      if (hole_ff <= j_ff) begin
         stays = (hole_ff < k_home) && (k_home <= j_ff);
      end else begin
         stays = (hole_ff < k_home) || (k_home <= j_ff);
      end
   end

   // decide what a finished probe leads to
   always_comb begin
      size_dbl   = {size_ff, 1'b0};
      grow_over  = size_dbl > (SW+1)'(MAX_SLOTS);
      is_full    = occ_ff >= size_ff;
      shrink_due = (occ_ff == (size_ff >> 1)) && (size_ff != SW'(2));
      found      = pres_ff == P_FOUND;
      place_ok   = pres_ff == P_EMPTY;
      act        = A_RESP;
      a_status   = lphs_pkg::ST_OK;
      a_slot     = '0;
      a_size     = size_dbl[SW-1:0];
      case (ret_ff)
         R_REHASH: begin
            act = A_REHASH;
         end
         R_FIRST: begin
            case (kind_ff)
               lphs_pkg::KIND_INSERT: begin
                  if (found) begin
                     a_status = lphs_pkg::ST_PRESENT;
                     a_slot   = pidx_ff;
                  end else if (is_full) begin
                     if (grow_over) begin
                        a_status = lphs_pkg::ST_FULL;
                     end else begin
                        act = A_RESIZE;
                     end
                  end else if (place_ok) begin
                     act = A_PLACE;
                  end else begin
                     a_status = lphs_pkg::ST_FULL;
                  end
               end
               lphs_pkg::KIND_DELETE: begin
                  if (!found) begin
                     a_status = lphs_pkg::ST_ABSENT;
                  end else if (shrink_due) begin
                     act    = A_RESIZE;
                     a_size = size_ff >> 1;
                  end else begin
                     act = A_REMOVE;
                  end
               end
               default: begin
                  if (found) begin
                     a_slot = pidx_ff;
                  end else begin
                     a_status = lphs_pkg::ST_ABSENT;
                  end
               end
            endcase
         end
         default: begin
            if (kind_ff == lphs_pkg::KIND_INSERT) begin
               if (place_ok) begin
                  act = A_PLACE;
               end else begin
                  a_status = lphs_pkg::ST_FULL;
               end
            end else if (found) begin
               act = A_REMOVE;
            end else begin
               a_status = lphs_pkg::ST_ABSENT;
            end
         end
      endcase
   end

   // key bank addressing and writes
   always_comb begin
      case (state_ff)
         S_RS_RD:   raddr = i_ff[IW-1:0];
         S_RM_STEP: raddr = jn;
         default:   raddr = idx_ff;
      endcase
      mem_we = 1'b0;
      waddr  = pidx_ff;
      wdata  = probe_key_ff;
      if (state_ff == S_DISP) begin
         mem_we = (act == A_PLACE) || ((act == A_REHASH) && place_ok);
      end else if (state_ff == S_RM_WAIT) begin
         mem_we = mod_done && !stays;
         waddr  = hole_ff;
         wdata  = jkey_ff;
      end
   end

   // feed the remainder unit
   assign mod_start = (state_ff == S_HOME) || (state_ff == S_RM_KEY);
   assign mod_a     = (state_ff == S_RM_KEY) ? rd_live : probe_key_ff;

   lphs_mod #(
      .KEY_BITS (KEY_BITS),
      .SIZE_W   (SW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_a),
      .divisor   (size_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // key banks: one write and one registered read each
   always_ff @(posedge clock) begin
      if (mem_we && !bank_ff) begin
         keys0[waddr] <= wdata;
      end
      if (mem_we && bank_ff) begin
         keys1[waddr] <= wdata;
      end
      rd0_ff <= keys0[raddr];
      rd1_ff <= keys1[raddr];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         occ_ff        <= '0;
         init_ff       <= lphs_pkg::INIT_SIZE_RST;
         size_ff       <= clamp_size(lphs_pkg::INIT_SIZE_RST);
         bank_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (csr_wr_en) begin
            init_ff <= csr_wr_data;
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  kind_ff <= req_word.kind;
                  if (req_word.kind == lphs_pkg::KIND_CLEAR) begin
                     valid_ff[bank_ff] <= '0;
                     occ_ff            <= '0;
                     size_ff           <= clamp_size(init_ff);
                     status_ff         <= lphs_pkg::ST_OK;
                     slot_ff           <= '0;
                     rsp_strobe_ff     <= 1'b1;
                  end else begin
                     key_ff       <= key_in;
                     probe_key_ff <= key_in;
                     ret_ff       <= R_FIRST;
                     state_ff     <= S_HOME;
                  end
               end
            end
            S_HOME: begin
               state_ff <= S_HWAIT;
            end
            S_HWAIT: begin
               if (mod_done) begin
                  idx_ff   <= mod_rem[IW-1:0];
                  pcnt_ff  <= '0;
                  state_ff <= S_PRD;
               end
            end
            // stop at an exhausted walk or an empty slot, else read the key
            S_PRD: begin
               if (pcnt_ff == size_ff) begin
                  pres_ff  <= P_NONE;
                  state_ff <= S_DISP;
               end else if (!valid_live[idx_ff]) begin
                  pres_ff  <= P_EMPTY;
                  pidx_ff  <= idx_ff;
                  state_ff <= S_DISP;
               end else begin
                  state_ff <= S_PCMP;
               end
            end
            S_PCMP: begin
               if (rd_live == probe_key_ff) begin
                  pres_ff  <= P_FOUND;
                  pidx_ff  <= idx_ff;
                  state_ff <= S_DISP;
               end else begin
                  idx_ff   <= idx_nx;
                  pcnt_ff  <= pcnt_ff + 1'b1;
                  state_ff <= S_PRD;
               end
            end
            S_DISP: begin
               case (act)
                  A_PLACE: begin
                     valid_ff[bank_ff][pidx_ff] <= 1'b1;
                     occ_ff        <= occ_ff + 1'b1;
                     status_ff     <= lphs_pkg::ST_OK;
                     slot_ff       <= pidx_ff;
                     rsp_strobe_ff <= 1'b1;
                     state_ff      <= S_IDLE;
                  end
                  A_REMOVE: begin
                     hole_ff   <= pidx_ff;
                     j_ff      <= pidx_ff;
                     n_ff      <= SW'(1);
                     slot_ff   <= pidx_ff;
                     status_ff <= lphs_pkg::ST_OK;
                     if (occ_ff != '0) begin
                        occ_ff <= occ_ff - 1'b1;
                     end
                     state_ff  <= S_RM_STEP;
                  end
                  // swap banks; the new live bank starts empty
                  A_RESIZE: begin
                     valid_ff[~bank_ff] <= '0;
                     bank_ff            <= ~bank_ff;
                     old_size_ff        <= size_ff;
                     size_ff            <= a_size;
                     i_ff               <= '0;
                     state_ff           <= S_RS_RD;
                  end
                  A_REHASH: begin
                     if (place_ok) begin
                        valid_ff[bank_ff][pidx_ff] <= 1'b1;
                     end
                     state_ff <= S_RS_RD;
                  end
                  default: begin
                     status_ff     <= a_status;
                     slot_ff       <= a_slot;
                     rsp_strobe_ff <= 1'b1;
                     state_ff      <= S_IDLE;
                  end
               endcase
            end
            // sweep old slots in order; skip empty ones
            S_RS_RD: begin
               if (i_ff == old_size_ff) begin
                  probe_key_ff <= key_ff;
                  ret_ff       <= R_SECOND;
                  state_ff     <= S_HOME;
               end else if (!valid_old[i_ff[IW-1:0]]) begin
                  i_ff <= i_ff + 1'b1;
               end else begin
                  state_ff <= S_RS_KEY;
               end
            end
            S_RS_KEY: begin
               probe_key_ff <= rd_old;
               ret_ff       <= R_REHASH;
               i_ff         <= i_ff + 1'b1;
               state_ff     <= S_HOME;
            end
            // walk the chain after the hole; drop the hole at its end
            S_RM_STEP: begin
               if ((n_ff == size_ff) || !valid_live[jn]) begin
                  valid_ff[bank_ff][hole_ff] <= 1'b0;
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end else begin
                  j_ff     <= jn;
                  state_ff <= S_RM_KEY;
               end
            end
            S_RM_KEY: begin
               jkey_ff  <= rd_live;
               state_ff <= S_RM_WAIT;
            end
            S_RM_WAIT: begin
               if (mod_done) begin
                  if (!stays) begin
                     hole_ff <= j_ff;
                  end
                  n_ff     <= n_ff + 1'b1;
                  state_ff <= S_RM_STEP;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // drive the response word
   always_comb begin
      slot_wide             = 32'(slot_ff);
      size_wide             = 32'(size_ff);
      rsp_word.status       = status_ff;
      rsp_word.slot_index   = slot_wide[lphs_pkg::SLOT_W-1:0];
      rsp_word.current_size = size_wide[lphs_pkg::SIZE_W-1:0];
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = rsp_strobe_ff;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench of linear_probe_hash_set_core: directed and random words.
// Depends on lphs_pkg and linear_probe_hash_set_core; predicts every response word.
`timescale 1ns / 100ps

module tb;

   localparam int NSLOT = 256;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   lphs_pkg::req_word_type req_word = '0;
   logic rsp_strobe;
   lphs_pkg::rsp_word_type rsp_word;
   logic csr_wr_en = 1'b0;
   logic [lphs_pkg::CSR_W-1:0] csr_wr_data = '0;

   linear_probe_hash_set_core DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_word(req_word),
      .rsp_strobe(rsp_strobe), .rsp_word(rsp_word),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow table
   logic [lphs_pkg::KEY_W-1:0] set_keys [NSLOT];
   logic                       set_used [NSLOT];
   int                         set_count;
   int                         set_size;
   int                         size_reg;

   lphs_pkg::req_word_type pending_words [$];
   lphs_pkg::rsp_word_type expected_rsps [$];
   int  mismatch_count = 0;
   bit  idle_enable = 1'b1;

   function automatic int clamp_size(input int v);
      if (v < 2) return 2;
      if (v > NSLOT) return NSLOT;
      return v;
   endfunction

   // walk from the home slot; stop at the key or a free slot
   function automatic bit find_slot(input logic [lphs_pkg::KEY_W-1:0] k, output int where);
      int idx;
      idx = k % set_size;
      for (int n = 0; n < set_size; n++) begin
         if (!set_used[idx]) begin
            where = idx;
            return 1'b0;
         end
         if (set_keys[idx] == k) begin
            where = idx;
            return 1'b1;
         end
         idx = (idx + 1 == set_size) ? 0 : idx + 1;
      end
      where = NSLOT;
      return 1'b0;
   endfunction

   // rehash the old slots in old-slot order
   function automatic void rehash(input int new_size);
      logic [lphs_pkg::KEY_W-1:0] old_keys [NSLOT];
      logic old_used [NSLOT];
      int old_size;
      int w;
      old_size = set_size;
      old_keys = set_keys;
      old_used = set_used;
      foreach (set_used[i]) set_used[i] = 1'b0;
      set_size = new_size;
      for (int i = 0; i < old_size; i++)
         if (old_used[i] && !find_slot(old_keys[i], w) && w < set_size) begin
            set_keys[w] = old_keys[i];
            set_used[w] = 1'b1;
         end
   endfunction

   // backward-shift removal keeps probe chains whole
   function automatic void shift_out(input int hole);
      int j;
      int k;
      bit stays;
      j = hole;
      for (int n = 1; n < set_size; n++) begin
         j = (j + 1 == set_size) ? 0 : j + 1;
         if (!set_used[j]) break;
         k = set_keys[j] % set_size;
         if (hole <= j) stays = (hole < k) && (k <= j);
         else stays = (hole < k) || (k <= j);
         if (!stays) begin
            set_keys[hole] = set_keys[j];
            hole = j;
         end
      end
      set_used[hole] = 1'b0;
   endfunction

   function automatic lphs_pkg::rsp_word_type apply_word(input lphs_pkg::req_word_type rq);
      lphs_pkg::rsp_word_type r;
      int w;
      r.status = lphs_pkg::ST_OK;
      r.slot_index = '0;
      case (rq.kind)
         lphs_pkg::KIND_LOOKUP: begin
            if (find_slot(rq.key, w)) r.slot_index = w[lphs_pkg::SLOT_W-1:0];
            else r.status = lphs_pkg::ST_ABSENT;
         end
         lphs_pkg::KIND_INSERT: begin
            if (find_slot(rq.key, w)) begin
               r.status = lphs_pkg::ST_PRESENT;
               r.slot_index = w[lphs_pkg::SLOT_W-1:0];
            end else if (set_count >= set_size && 2 * set_size > NSLOT) begin
               r.status = lphs_pkg::ST_FULL;
            end else begin
               if (set_count >= set_size) rehash(2 * set_size);
               if (!find_slot(rq.key, w) && w < set_size) begin
                  set_keys[w] = rq.key;
                  set_used[w] = 1'b1;
                  set_count++;
                  r.slot_index = w[lphs_pkg::SLOT_W-1:0];
               end else r.status = lphs_pkg::ST_FULL;
            end
         end
         lphs_pkg::KIND_DELETE: begin
            if (!find_slot(rq.key, w)) r.status = lphs_pkg::ST_ABSENT;
            else begin
               if (set_count == set_size / 2 && set_size != 2) rehash(set_size / 2);
               if (find_slot(rq.key, w)) begin
                  shift_out(w);
                  if (set_count > 0) set_count--;
                  r.slot_index = w[lphs_pkg::SLOT_W-1:0];
               end else r.status = lphs_pkg::ST_ABSENT;
            end
         end
         default: begin
            foreach (set_used[i]) set_used[i] = 1'b0;
            set_count = 0;
            set_size = clamp_size(size_reg);
         end
      endcase
      r.current_size = set_size[lphs_pkg::SIZE_W-1:0];
      return r;
   endfunction

   // driver: hold start until busy is low at an edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            expected_rsps.push_back(apply_word(req_word));
            void'(pending_words.pop_front());
         end
         if ((!start || !busy) && pending_words.size() > 0 &&
             !(idle_enable && $urandom_range(99) < 18)) begin
            start <= 1'b1;
            req_word <= (start && !busy) ? pending_words[0] : pending_words[0];
         end else if (!start || !busy) begin
            start <= 1'b0;
         end
      end
   end

   // monitor: compare each strobed word with the oldest expectation
   always @(posedge clock) begin
      lphs_pkg::rsp_word_type e;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected word %p", rsp_word);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_word.status !== e.status || rsp_word.slot_index !== e.slot_index ||
                rsp_word.current_size !== e.current_size) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p actual %p", e, rsp_word);
            end
         end
      end
   end

   task automatic drain();
      while (pending_words.size() > 0 || start || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_size(input int v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v[lphs_pkg::CSR_W-1:0];
      size_reg = v & 'h1FF;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic void add_word(input lphs_pkg::kind_type kd, input int k);
      lphs_pkg::req_word_type rq;
      rq.kind = kd;
      rq.key = k[lphs_pkg::KEY_W-1:0];
      pending_words.push_back(rq);
   endfunction

   // keys from a small pool so hits, duplicates and chains are common
   function automatic int pick_key(input int pool_span);
      if ($urandom_range(9) == 0) return $urandom_range(21'h1FFFFF);
      return $urandom_range(pool_span) * ($urandom_range(1) ? 1 : 16);
   endfunction

   function automatic lphs_pkg::kind_type pick_kind();
      int r;
      r = $urandom_range(99);
      if (r < 45) return lphs_pkg::KIND_INSERT;
      if (r < 75) return lphs_pkg::KIND_DELETE;
      if (r < 98) return lphs_pkg::KIND_LOOKUP;
      return lphs_pkg::KIND_CLEAR;
   endfunction

   initial begin
      int sizes [6];
      sizes = '{16, 2, 3, 256, 300, 0};
      foreach (set_used[i]) set_used[i] = 1'b0;
      set_count = 0;
      size_reg = lphs_pkg::INIT_SIZE_RST;
      set_size = clamp_size(size_reg);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every operation, duplicate, absent
      add_word(lphs_pkg::KIND_LOOKUP, 0);
      add_word(lphs_pkg::KIND_INSERT, 0);
      add_word(lphs_pkg::KIND_INSERT, 21'h1FFFFF);
      add_word(lphs_pkg::KIND_INSERT, 0);
      add_word(lphs_pkg::KIND_LOOKUP, 21'h1FFFFF);
      add_word(lphs_pkg::KIND_INSERT, 16);
      add_word(lphs_pkg::KIND_INSERT, 32);
      add_word(lphs_pkg::KIND_DELETE, 0);
      add_word(lphs_pkg::KIND_LOOKUP, 32);
      add_word(lphs_pkg::KIND_DELETE, 5);
      add_word(lphs_pkg::KIND_LOOKUP, 21'h155555);
      add_word(lphs_pkg::KIND_INSERT, 21'h0AAAAA);
      add_word(lphs_pkg::KIND_CLEAR, 0);
      drain();

      // tiny table: grow, shrink to one slot, and capacity overflow at 256
      write_size(3);
      add_word(lphs_pkg::KIND_CLEAR, 0);
      for (int i = 0; i < 4; i++) add_word(lphs_pkg::KIND_INSERT, i * 7);
      for (int i = 0; i < 4; i++) add_word(lphs_pkg::KIND_DELETE, i * 7);
      add_word(lphs_pkg::KIND_LOOKUP, 7);
      drain();
      write_size(256);
      add_word(lphs_pkg::KIND_CLEAR, 0);
      for (int i = 0; i < 258; i++) add_word(lphs_pkg::KIND_INSERT, i * 3 + 1);
      for (int i = 0; i < 140; i++) add_word(lphs_pkg::KIND_DELETE, i * 3 + 1);
      drain();

      // random phases over several sizes
      foreach (sizes[p]) begin
         write_size(sizes[p] == 300 ? 300 : (sizes[p] == 0 ? $urandom_range(511) : sizes[p]));
         add_word(lphs_pkg::KIND_CLEAR, 0);
         idle_enable = (p != 2);
         for (int i = 0; i < 150; i++)
            add_word(pick_kind(), pick_key(sizes[p] == 256 ? 80 : 24));
         drain();
      end
      if (expected_rsps.size() == 0 && mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #400ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule

// ===== linear_probe_hash_set_core.f =====
sv/lphs_pkg.sv
sv/lphs_mod.sv
sv/linear_probe_hash_set_core.sv
verif/tb.sv
